[sv/ppad_pkg.sv]
// Shared types and codes for the polyline position-at-distance block.
`default_nettype none
package ppad_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam int COORD_W = 24;
  localparam int DIST_W  = 32;
  localparam int PCNT_W  = 7;
  localparam int FRAC_W  = 16;

  typedef struct packed {
    op_t                       op;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [DIST_W-1:0]         travel;
  } cmd_t;

  typedef struct packed {
    logic                      status;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic                      at_end;
    logic [PCNT_W-1:0]         point_count;
  } res_t;

endpackage
`default_nettype wire

[sv/ppad_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ppad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/ppad_front.sv]
// Input side: accepts words, decodes the opcode and queues up to two commands.
`default_nettype none
module ppad_front
  import ppad_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_push,
  output logic                           in_full,
  input  wire logic [1:0]                in_opcode,
  input  wire logic signed [COORD_W-1:0] in_point_x,
  input  wire logic signed [COORD_W-1:0] in_point_y,
  input  wire logic [DIST_W-1:0]         in_travel,
  output logic                           cmd_valid,
  output cmd_t                           cmd,
  input  wire logic                      cmd_pop
);

  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic       push_ok;
  logic       pop_ok;
  cmd_t       in_cmd;

  always_comb begin
    in_cmd.op     = op_t'(in_opcode);
    in_cmd.x      = in_point_x;
    in_cmd.y      = in_point_y;
    in_cmd.travel = in_travel;
  end

  assign in_full   = (fill_r == 2'd2);
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push_ok) begin
        q_r[wr_ptr_r] <= in_cmd;
        wr_ptr_r      <= ~wr_ptr_r;
      end
      if (pop_ok) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      fill_r <= fill_r + 2'(push_ok) - 2'(pop_ok);
    end
  end

endmodule
`default_nettype wire

[sv/ppad_back.sv]
// Execution side: path storage, segment length root, walk, divide and lerp.
`default_nettype none
module ppad_back
  import ppad_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      out_valid,
  output res_t      out_res,
  input  wire logic out_pop
);

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int CWX  = (CW > PCNT_W) ? CW : PCNT_W;
  localparam int SQ_W = 2 * COORD_W + 1;
  localparam int RD_W = SQ_W + 1;
  localparam int PR_W = COORD_W + 1 + FRAC_W + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_SUM, S_ROOT, S_SEGW, S_QRD, S_QCHK,
    S_QDIV, S_QRA, S_QRB, S_QRC, S_QMUL, S_QFIN, S_EMIT
  } state_t;

  state_t                    state_r;
  logic [CW-1:0]             count_r;
  logic [DIST_W-1:0]         total_r;
  logic signed [COORD_W-1:0] last_x_r, last_y_r;
  cmd_t                      cmd_r;
  logic signed [COORD_W:0]   dx_r, dy_r;
  logic [SQ_W-1:0]           sqx_r, sqy_r;
  logic [RD_W-1:0]           v_r, root_r, bit_r;
  logic [AW-1:0]             i_r;
  logic [DIST_W-1:0]         ln_r;
  logic [DIST_W:0]           rem_r;
  logic [FRAC_W:0]           q_r;
  logic [4:0]                div_cnt_r;
  logic                      zero_len_r;
  logic signed [COORD_W-1:0] ax_r, ay_r;
  logic signed [COORD_W:0]   ddx_r, ddy_r;
  logic signed [PR_W-1:0]    prx_r, pry_r;
  res_t                      work_r;
  res_t                      out_r;
  logic                      out_valid_r;

  logic                      slot_free;
  logic                      xy_we, seg_we;
  logic [AW-1:0]             xy_waddr, seg_waddr, xy_raddr;
  logic signed [COORD_W-1:0] x_rd, y_rd;
  logic [DIST_W-1:0]         st_rd, ln_rd;
  logic signed [2*COORD_W+1:0] sq_full;
  logic [RD_W-1:0]           trial;
  logic [DIST_W:0]           sum33, end33;
  logic [DIST_W-1:0]         off;
  logic [DIST_W:0]           rem2;
  logic                      div_ge;
  logic signed [PR_W-1:0]    adj_x, adj_y, shf_x, shf_y;
  logic [CWX-1:0]            count_ext;
  logic                      full_drop, q_first, q_last, q_tail;
  state_t                    idle_state;

  assign slot_free = !out_valid_r || out_pop;
  assign cmd_pop   = (state_r == S_IDLE) && cmd_valid;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  assign xy_we     = cmd_pop && (cmd.op == OP_APPEND) && (count_r < CW'(MAX_POINTS));
  assign xy_waddr  = count_r[AW-1:0];
  assign seg_we    = (state_r == S_SEGW);
  assign seg_waddr = AW'(count_r - CW'(1));
  assign xy_raddr  = (state_r == S_QRB) ? AW'(i_r + AW'(1)) : i_r;

  ppad_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk(clk), .we(xy_we), .waddr(xy_waddr), .wdata(cmd.x),
    .raddr(xy_raddr), .rdata(x_rd)
  );
  ppad_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk(clk), .we(xy_we), .waddr(xy_waddr), .wdata(cmd.y),
    .raddr(xy_raddr), .rdata(y_rd)
  );
  ppad_ram #(.WIDTH(DIST_W), .DEPTH(MAX_POINTS)) u_ram_len (
    .clk(clk), .we(seg_we), .waddr(seg_waddr), .wdata(root_r[DIST_W-1:0]),
    .raddr(i_r), .rdata(ln_rd)
  );
  ppad_ram #(.WIDTH(DIST_W), .DEPTH(MAX_POINTS)) u_ram_start (
    .clk(clk), .we(seg_we), .waddr(seg_waddr), .wdata(total_r),
    .raddr(i_r), .rdata(st_rd)
  );

  always_comb begin
    sq_full   = (state_r == S_SQX) ? dx_r * dx_r : dy_r * dy_r;
    trial     = root_r + bit_r;
    sum33     = {1'b0, total_r} + {1'b0, root_r[DIST_W-1:0]};
    end33     = {1'b0, st_rd} + {1'b0, ln_rd};
    off       = (cmd_r.travel > st_rd) ? cmd_r.travel - st_rd : '0;
    rem2      = {rem_r[DIST_W-1:0], 1'b0};
    div_ge    = rem2 >= {1'b0, ln_r};
    adj_x     = prx_r + (prx_r[PR_W-1] ? PR_W'(65535) : '0);
    adj_y     = pry_r + (pry_r[PR_W-1] ? PR_W'(65535) : '0);
    shf_x     = adj_x >>> FRAC_W;
    shf_y     = adj_y >>> FRAC_W;
    count_ext = CWX'(count_r);
  end

  // Classify the waiting command so that the idle state loads each register once.
  always_comb begin
    full_drop  = (cmd.op == OP_APPEND) && (count_r >= CW'(MAX_POINTS));
    q_first    = (count_r == CW'(1)) || (cmd.travel == '0);
    q_last     = (cmd.travel >= total_r);
    q_tail     = (cmd.op == OP_QUERY) && (count_r != '0) && !q_first && q_last;
    idle_state = S_EMIT;
    unique case (cmd.op)
      OP_APPEND: begin
        if (!full_drop && count_r != '0) idle_state = S_SQX;
      end
      OP_QUERY: begin
        if (count_r == '0) idle_state = S_EMIT;
        else if (q_first) idle_state = S_QRA;
        else if (!q_last) idle_state = S_QRD;
      end
      OP_CLEAR, OP_NONE: idle_state = S_EMIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_pop && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r          <= cmd;
            work_r.status  <= full_drop ? STATUS_FULL : STATUS_DONE;
            work_r.pos_x   <= q_tail ? last_x_r : '0;
            work_r.pos_y   <= q_tail ? last_y_r : '0;
            work_r.at_end  <= (cmd.op == OP_QUERY) && q_last;
            zero_len_r     <= (cmd.op == OP_QUERY) && q_first;
            i_r            <= '0;
            state_r        <= idle_state;
            unique case (cmd.op)
              OP_CLEAR: begin
                count_r <= '0;
                total_r <= '0;
              end
              OP_APPEND: begin
                if (!full_drop) begin
                  last_x_r <= cmd.x;
                  last_y_r <= cmd.y;
                  if (count_r == '0) begin
                    count_r <= CW'(1);
                  end else begin
                    dx_r <= {cmd.x[COORD_W-1], cmd.x} - {last_x_r[COORD_W-1], last_x_r};
                    dy_r <= {cmd.y[COORD_W-1], cmd.y} - {last_y_r[COORD_W-1], last_y_r};
                  end
                end
              end
              OP_QUERY, OP_NONE: begin
              end
            endcase
          end
        end
        S_SQX: begin
          sqx_r   <= sq_full[SQ_W-1:0];
          state_r <= S_SQY;
        end
        S_SQY: begin
          sqy_r   <= sq_full[SQ_W-1:0];
          state_r <= S_SUM;
        end
        S_SUM: begin
          v_r     <= RD_W'(sqx_r) + RD_W'(sqy_r);
          root_r  <= '0;
          bit_r   <= RD_W'(1) << (2 * COORD_W);
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (v_r >= trial) begin
            v_r    <= v_r - trial;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            state_r <= S_SEGW;
          end
        end
        S_SEGW: begin
          total_r <= sum33[DIST_W] ? '1 : sum33[DIST_W-1:0];
          count_r <= count_r + CW'(1);
          state_r <= S_EMIT;
        end
        S_QRD: begin
          state_r <= S_QCHK;
        end
        S_QCHK: begin
          if ({1'b0, cmd_r.travel} <= end33) begin
            ln_r <= ln_rd;
            if (ln_rd == '0) begin
              zero_len_r <= 1'b1;
              state_r    <= S_QRA;
            end else begin
              rem_r     <= (off >= ln_rd) ? {1'b0, off - ln_rd} : {1'b0, off};
              q_r       <= (FRAC_W + 1)'(off >= ln_rd);
              div_cnt_r <= 5'(FRAC_W);
              state_r   <= S_QDIV;
            end
          end else if ((CW + 1)'(i_r) + (CW + 1)'(2) < (CW + 1)'(count_r)) begin
            i_r     <= i_r + AW'(1);
            state_r <= S_QRD;
          end else begin
            work_r.pos_x <= last_x_r;
            work_r.pos_y <= last_y_r;
            state_r      <= S_EMIT;
          end
        end
        S_QDIV: begin
          rem_r     <= div_ge ? rem2 - {1'b0, ln_r} : rem2;
          q_r       <= {q_r[FRAC_W-1:0], div_ge};
          div_cnt_r <= div_cnt_r - 5'd1;
          if (div_cnt_r == 5'd1) begin
            state_r <= S_QRA;
          end
        end
        S_QRA: begin
          state_r <= S_QRB;
        end
        S_QRB: begin
          ax_r <= x_rd;
          ay_r <= y_rd;
          if (zero_len_r) begin
            work_r.pos_x <= x_rd;
            work_r.pos_y <= y_rd;
            state_r      <= S_EMIT;
          end else begin
            state_r <= S_QRC;
          end
        end
        S_QRC: begin
          ddx_r   <= {x_rd[COORD_W-1], x_rd} - {ax_r[COORD_W-1], ax_r};
          ddy_r   <= {y_rd[COORD_W-1], y_rd} - {ay_r[COORD_W-1], ay_r};
          state_r <= S_QMUL;
        end
        S_QMUL: begin
          prx_r   <= PR_W'(ddx_r * $signed({1'b0, q_r}));
          pry_r   <= PR_W'(ddy_r * $signed({1'b0, q_r}));
          state_r <= S_QFIN;
        end
        S_QFIN: begin
          work_r.pos_x <= ax_r + shf_x[COORD_W-1:0];
          work_r.pos_y <= ay_r + shf_y[COORD_W-1:0];
          state_r      <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_r       <= '{work_r.status, work_r.pos_x, work_r.pos_y, work_r.at_end,
                             count_ext[PCNT_W-1:0]};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_POINTS))
    else $error("point count above store depth");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_pop |=> out_valid_r)
    else $error("waiting result lost");
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && slot_free |=> out_valid_r && state_r == S_IDLE)
    else $error("result not loaded on emit");
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_QMUL |-> q_r <= (FRAC_W + 1)'(65536))
    else $error("interpolation fraction above one");
`endif

endmodule
`default_nettype wire

[sv/polyline_position_at_distance.sv]
// Top level of the polyline position-at-distance block.
`default_nettype none
// This block stores a polyline of up to MAX_POINTS waypoints and answers
// position-at-distance queries along it. Each input word is a clear, an
// append, a query or an unused opcode, and each produces exactly one
// result word in order. Input words land in a two-word command queue, so
// the source can keep pushing while the execution engine is busy; results
// wait in a one-word output register until popped. An append that adds a
// point after the first runs the 25-step bit-serial square root of
// dx*dx + dy*dy. A query walks the segments, each step one read of the
// length and start memories and one compare, which also yields the top
// fraction bit, then restoring division for the rest of the 16-bit
// fraction, and last point fetch, interpolation and result load. Queries
// that hit the start or end of the path skip the walk. The store memories
// need no clearing pass after reset.
module polyline_position_at_distance
  import ppad_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_push,
  output logic                           in_full,
  input  wire logic [1:0]                in_opcode,
  input  wire logic signed [COORD_W-1:0] in_point_x,
  input  wire logic signed [COORD_W-1:0] in_point_y,
  input  wire logic [DIST_W-1:0]         in_travel,
  output logic                           out_empty,
  input  wire logic                      out_pop,
  output logic                           out_status,
  output logic signed [COORD_W-1:0]      out_pos_x,
  output logic signed [COORD_W-1:0]      out_pos_y,
  output logic                           out_at_end,
  output logic [PCNT_W-1:0]              out_point_count
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic res_valid;
  res_t res;

  // The front end only queues and decodes; all path state lives in the back end.
  ppad_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_opcode(in_opcode),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_travel(in_travel),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  ppad_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .out_valid(res_valid), .out_res(res), .out_pop(out_pop)
  );

  // The result register presents the oldest word whenever it is not empty.
  assign out_empty       = !res_valid;
  assign out_status      = res.status;
  assign out_pos_x       = res.pos_x;
  assign out_pos_y       = res.pos_y;
  assign out_at_end      = res.at_end;
  assign out_point_count = res.point_count;

endmodule
`default_nettype wire

[tb/polyline_position_at_distance_tb.sv]
// Self-checking testbench for the polyline position-at-distance block.
`default_nettype none

// Scoreboard: holds its own copy of the polyline and predicts one result word per input word.
class path_scoreboard;
  int                  max_pts;
  logic signed [23:0]  pt_x[$];
  logic signed [23:0]  pt_y[$];
  logic [31:0]         seg_len[$];
  logic [31:0]         seg_start[$];
  logic [31:0]         total_len;
  ppad_pkg::res_t      expected_words[$];
  int                  mismatches;

  function new(int max_points);
    max_pts = max_points;
    total_len = 0;
    mismatches = 0;
  endfunction

  // Floor square root, one result bit at a time.
  function automatic logic [31:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res[31:0];
  endfunction

  // Start plus the truncated offset toward the end point.
  function automatic logic signed [23:0] blend(logic signed [23:0] a, logic signed [23:0] b,
                                               longint t);
    longint d;
    d = longint'(b) - longint'(a);
    return 24'(longint'(a) + (d * t) / 65536);
  endfunction

  function void note_word(logic [1:0] op, logic signed [23:0] x, logic signed [23:0] y,
                          logic [31:0] travel);
    ppad_pkg::res_t r;
    longint dx, dy;
    logic [63:0] sq, sum, off, st, ln;
    logic [31:0] len;
    longint t;
    int n;
    bit found;
    r = '0;
    n = pt_x.size();
    case (ppad_pkg::op_t'(op))
      ppad_pkg::OP_CLEAR: begin
        pt_x.delete(); pt_y.delete(); seg_len.delete(); seg_start.delete();
        total_len = 0;
      end
      ppad_pkg::OP_APPEND: begin
        if (n >= max_pts) begin
          r.status = ppad_pkg::STATUS_FULL;
        end else begin
          if (n >= 1) begin
            dx = longint'(x) - longint'(pt_x[n-1]);
            dy = longint'(y) - longint'(pt_y[n-1]);
            sq = 64'(dx * dx) + 64'(dy * dy);
            len = floor_sqrt(sq);
            sum = 64'(total_len) + 64'(len);
            seg_len = {seg_len, len};
            seg_start = {seg_start, total_len};
            total_len = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
          end
          pt_x = {pt_x, x};
          pt_y = {pt_y, y};
        end
      end
      ppad_pkg::OP_QUERY: begin
        r.at_end = travel >= total_len;
        if (n == 0) begin
          r.pos_x = 0; r.pos_y = 0;
        end else if (n == 1 || travel == 0) begin
          r.pos_x = pt_x[0]; r.pos_y = pt_y[0];
        end else begin
          r.pos_x = pt_x[n-1]; r.pos_y = pt_y[n-1];
          found = 0;
          if (!r.at_end) begin
            for (int i = 0; i + 1 < n && !found; i++) begin
              st = seg_start[i];
              ln = seg_len[i];
              if (64'(travel) <= st + ln) begin
                found = 1;
                if (ln == 0) begin
                  r.pos_x = pt_x[i]; r.pos_y = pt_y[i];
                end else begin
                  off = (64'(travel) > st) ? 64'(travel) - st : 0;
                  t = longint'((off << 16) / ln);
                  r.pos_x = blend(pt_x[i], pt_x[i+1], t);
                  r.pos_y = blend(pt_y[i], pt_y[i+1], t);
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.point_count = 7'(pt_x.size());
    expected_words = {expected_words, r};
  endfunction

  function void check_word(ppad_pkg::res_t got);
    ppad_pkg::res_t exp_w;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: unexpected result word %h", got);
      return;
    end
    exp_w = expected_words.pop_front();
    if (got !== exp_w) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: result mismatch (expected/actual): status %0d/%0d at_end %0d/%0d",
                 exp_w.status, got.status, exp_w.at_end, got.at_end);
        $display("       pos_x %0d/%0d pos_y %0d/%0d count %0d/%0d",
                 exp_w.pos_x, got.pos_x, exp_w.pos_y, got.pos_y,
                 exp_w.point_count, got.point_count);
      end
    end
  endfunction
endclass

module polyline_position_at_distance_tb;
  import ppad_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PTS    = 64;
  localparam int STALL_LIMIT = 20000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  logic                in_full;
  logic [1:0]          in_opcode = OP_CLEAR;
  logic signed [23:0]  in_point_x = '0;
  logic signed [23:0]  in_point_y = '0;
  logic [31:0]         in_travel = '0;
  logic                out_empty;
  logic                out_pop = 1'b0;
  logic                out_status;
  logic signed [23:0]  out_pos_x;
  logic signed [23:0]  out_pos_y;
  logic                out_at_end;
  logic [6:0]          out_point_count;

  // Idle percentages; the phase plan below changes them.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // While set, the receiver refuses to pop; counted down in the receiver process.
  int hold_cycles = 0;
  int quiet_cycles = 0;

  path_scoreboard sb;

  always #4 clk = ~clk;

  polyline_position_at_distance #(.MAX_POINTS(MAX_PTS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_opcode(in_opcode), .in_point_x(in_point_x), .in_point_y(in_point_y),
    .in_travel(in_travel),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_status(out_status), .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_at_end(out_at_end), .out_point_count(out_point_count)
  );

  // Offer one word and hold it until the block takes it. Random idle cycles
  // go in front of the word, so push drops only between words.
  task automatic send_word(logic [1:0] op, logic signed [23:0] x, logic signed [23:0] y,
                           logic [31:0] travel);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push    <= 1'b1;
    in_opcode  <= op;
    in_point_x <= x;
    in_point_y <= y;
    in_travel  <= travel;
    do @(posedge clk); while (!(in_push && !in_full));
    sb.note_word(op, x, y, travel);
  endtask

  task automatic release_push();
    in_push <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    release_push();
    while (sb.expected_words.size() != 0) @(posedge clk);
  endtask

  // Coordinates near the origin half the time, otherwise anywhere in the range
  // or at its extremes, so that short and long segment walks get exercised.
  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return $urandom_range(1) ? 24'sh7FFFFF : -24'sh800000;
      default: return 24'(int'($urandom_range(4000)) - 2000);
    endcase
  endfunction

  // Distances aimed at the current path: inside, at segment ends, past the end.
  function automatic logic [31:0] rand_travel();
    int k;
    case ($urandom_range(5))
      0: return $urandom;
      1: return 0;
      2: return sb.total_len;
      3: begin
        k = sb.seg_start.size();
        if (k == 0) return $urandom_range(300);
        k = $urandom_range(k - 1);
        return sb.seg_start[k] + sb.seg_len[k];
      end
      default: return (sb.total_len == 0) ? $urandom_range(500) :
                      32'($urandom % (64'(sb.total_len) + 1));
    endcase
  endfunction

  // One random word: a well-formed path is mostly appends and queries,
  // with an occasional clear or unused opcode as noise.
  task automatic send_random_word();
    int r;
    r = $urandom_range(99);
    if (r < 3)
      send_word(OP_CLEAR, 24'($urandom), 24'($urandom), $urandom);
    else if (r < 5)
      send_word(OP_NONE, 24'($urandom), 24'($urandom), $urandom);
    else if (r < 50)
      send_word(OP_APPEND, rand_coord(), rand_coord(), $urandom);
    else
      send_word(OP_QUERY, 24'($urandom), 24'($urandom), rand_travel());
  endtask

  // Receiver: pops at random, honoring a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty)
        sb.check_word('{out_status, out_pos_x, out_pos_y, out_at_end, out_point_count});
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: counts cycles in which no word moves on either side.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** polyline_position_at_distance: FAILED **");
      $finish;
    end
  end

  initial begin
    sb = new(MAX_PTS);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty path, single point, extremes, a zero-length segment,
    // exact segment ends, and the unused opcode.
    send_word(OP_QUERY, '0, '0, 32'd0);
    send_word(OP_QUERY, '0, '0, 32'hFFFF_FFFF);
    send_word(OP_APPEND, -24'sd256, 24'sd512, '0);
    send_word(OP_QUERY, '0, '0, 32'd100);
    send_word(OP_APPEND, 24'sd1024, 24'sd512, '0);
    send_word(OP_APPEND, 24'sd1024, 24'sd512, '0);
    send_word(OP_APPEND, 24'sd1024, -24'sd300, '0);
    send_word(OP_QUERY, '0, '0, 32'd0);
    send_word(OP_QUERY, '0, '0, 32'd640);
    send_word(OP_QUERY, '0, '0, 32'd1280);
    send_word(OP_QUERY, '0, '0, 32'd1281);
    send_word(OP_QUERY, '0, '0, 32'd1500);
    send_word(OP_QUERY, '0, '0, 32'hFFFF_FFFF);
    send_word(OP_NONE, 24'sh7FFFFF, -24'sh800000, 32'hFFFF_FFFF);
    send_word(OP_CLEAR, '0, '0, '0);
    send_word(OP_APPEND, -24'sh800000, -24'sh800000, '0);
    send_word(OP_APPEND, 24'sh7FFFFF, 24'sh7FFFFF, '0);
    for (int i = 0; i < 6; i++)
      send_word(OP_APPEND, (i % 2) ? 24'sh7FFFFF : -24'sh800000, 24'sh7FFFFF, '0);
    send_word(OP_QUERY, '0, '0, 32'hFFFF_FFFE);
    send_word(OP_QUERY, '0, '0, 32'h1234_5678);
    send_word(OP_CLEAR, '0, '0, '0);

    // Fill the store to capacity and beyond, with the receiver held off so the
    // command queue backs up and in_full is seen.
    hold_cycles = 400;
    for (int i = 0; i < MAX_PTS + 3; i++)
      send_word(OP_APPEND, 24'(i * 97), 24'(-i * 55), '0);
    send_word(OP_QUERY, '0, '0, rand_travel());
    wait_drained();
    send_word(OP_CLEAR, '0, '0, '0);

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 57 : (ph == 3) ? 34 : 0;
      recv_stall_pct = (ph == 2) ? 57 : (ph == 3) ? 34 : 0;
      for (int i = 0; i < 90; i++) send_random_word();
      // Sender pauses until every result is back.
      wait_drained();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    wait_drained();
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
      $display("** polyline_position_at_distance: PASSED **");
    end else begin
      $display("** polyline_position_at_distance: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
sv/ppad_pkg.sv
sv/ppad_ram.sv
sv/ppad_front.sv
sv/ppad_back.sv
sv/polyline_position_at_distance.sv
tb/polyline_position_at_distance_tb.sv
